>>> rtl/bta_pkg.sv
// Shared types, constants and command/status bundles of the boundary-tag allocator.
package bta_pkg;

    localparam int DEF_HEAP_BYTES = 1024;
    localparam int REQ_W          = 11;
    localparam int OFS_W          = 10;
    localparam int STATUS_W       = 2;
    localparam int NEED_W         = 12;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 16;
    localparam int MIN_BLOCK      = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_NOMEM = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RA_H    = 2'd0,
        RA_NX   = 2'd1,
        RA_PREV = 2'd2
    } t_rd_sel;

    typedef enum logic [3:0] {
        WS_FMT    = 4'd0,
        WS_A_HDR  = 4'd1,
        WS_A_FTR  = 4'd2,
        WS_A_RHDR = 4'd3,
        WS_A_RFTR = 4'd4,
        WS_SZ_HDR = 4'd5,
        WS_SZ_FTR = 4'd6,
        WS_P_HDR  = 4'd7,
        WS_P_FTR  = 4'd8
    } t_wr_sel;

    typedef enum logic [1:0] {
        H_HOLD = 2'd0,
        H_ZERO = 2'd1,
        H_OFF  = 2'd2,
        H_ADV  = 2'd3
    } t_h_op;

    typedef enum logic [1:0] {
        SZ_HOLD = 2'd0,
        SZ_LOAD = 2'd1,
        SZ_ADD  = 2'd2
    } t_sz_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_h_op   h_op;
        t_sz_op  sz_op;
        logic    res_set;
        t_status res_code;
        logic    res_ofs;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic req_zero;
        logic formatted;
        logic need_big;
        logic fmt_last;
        logic off_bad;
        logic tag_alloc;
        logic fits;
        logic fit_ok;
        logic rest_nz;
        logic walk_end;
        logic nx_in;
        logic h_nz;
        logic prev_ok;
    } t_stat;

endpackage

>>> rtl/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit heap allocator.
// Allocate walks the blocks first-fit, then writes two tags, or four when it splits; the first
// non-zero allocation adds a format sweep over the whole heap. Free rewrites tags and merges.
// One item is in work at a time; the rate is set by the walk, one heap read per block
// through the single registered read port. A result waits in an output register while
// the next item is accepted. Reset (synchronous, active low) marks the heap unformatted.
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_BYTES = bta_pkg::DEF_HEAP_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // request_size [10:0], block_offset [20:11], zero fill [23:21]
    input  logic [bta_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // action: 0 allocate, 1 free
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status [1:0], payload_offset [11:2], zero fill [15:12]
    output logic [bta_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import bta_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [STATUS_W-1:0] status;
    logic [OFS_W-1:0]    ofs;

    // sequencer: decides each step from the datapath flags
    bta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: heap memory, pointers and the result register
    bta_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (i_s_tuser),
        .i_req    (i_s_tdata[REQ_W-1:0]),
        .i_off    (i_s_tdata[REQ_W+OFS_W-1:REQ_W]),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_status (status),
        .o_ofs    (ofs)
    );

    // pack the result beat, status in the lowest bits
    assign o_m_tdata = {(OUT_TDATA_W - STATUS_W - OFS_W)'(0), ofs, status};

endmodule

>>> rtl/bta_dp.sv
// Datapath of the allocator: heap memory, block pointers, size arithmetic and result registers.
module bta_dp #(
    parameter int HEAP_BYTES = bta_pkg::DEF_HEAP_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_action,
    input  logic [bta_pkg::REQ_W-1:0]    i_req,
    input  logic [bta_pkg::OFS_W-1:0]    i_off,
    input  bta_pkg::t_cmd                i_cmd,
    output bta_pkg::t_stat               o_stat,
    output logic [bta_pkg::STATUS_W-1:0] o_status,
    output logic [bta_pkg::OFS_W-1:0]    o_ofs
);
    import bta_pkg::*;

    localparam int NWORDS = HEAP_BYTES / 4;
    localparam int AW     = $clog2(NWORDS);
    localparam int HW     = AW + 1;
    localparam int TW     = $clog2(HEAP_BYTES + 1);
    localparam int CW0    = (TW > HW) ? TW : HW;
    localparam int CW     = ((CW0 > NEED_W) ? CW0 : NEED_W) + 1;

    localparam logic [CW-1:0] C_NWORDS = CW'(NWORDS);
    localparam logic [CW-1:0] C_HEAP   = CW'(HEAP_BYTES);
    localparam logic [CW-1:0] C_MIN    = CW'(MIN_BLOCK);
    localparam logic [CW-1:0] C_ONE    = CW'(1);
    localparam logic [AW-1:0] C_LAST   = AW'(NWORDS - 1);

    logic [TW-1:0]     mem [NWORDS];

    logic              r_action;
    logic [REQ_W-1:0]  r_req;
    logic [OFS_W-1:0]  r_off;
    logic [HW-1:0]     r_h;
    logic [HW-1:0]     r_base;
    logic [TW-1:0]     r_sz;
    logic [TW-1:0]     r_rdata;
    logic [AW-1:0]     r_fcnt;
    logic              r_fmt;
    t_status           r_res_status;
    logic [OFS_W-1:0]  r_res_ofs;
    logic [STATUS_W-1:0] r_o_status;
    logic [OFS_W-1:0]  r_o_ofs;

    logic [NEED_W-1:0] need12;
    logic [CW-1:0]     needc, hc, szc, rszc, basec, restc, nxc, fhc, ofs_full;
    logic [CW-1:0]     raddr_c, waddr_c, wdata_c;
    logic [AW-1:0]     waddr;
    logic [TW-1:0]     wdata;

    // round the request up to whole double words and add room for both tags
    assign need12 = ((NEED_W'(r_req) + NEED_W'(7)) & ~NEED_W'(7)) + NEED_W'(8);
    assign needc  = CW'(need12);
    assign hc     = CW'(r_h);
    assign szc    = CW'(r_sz);
    assign rszc   = CW'({r_rdata[TW-1:1], 1'b0});
    assign basec  = CW'(r_base);
    assign restc  = szc - needc;
    assign nxc    = hc + (szc >> 2);
    assign fhc    = CW'(r_off[OFS_W-1:2]) - C_ONE;
    assign ofs_full = (hc + C_ONE) << 2;

    always_comb begin
        o_stat.is_alloc  = !r_action;
        o_stat.req_zero  = (r_req == '0);
        o_stat.formatted = r_fmt;
        o_stat.need_big  = (needc > C_HEAP);
        o_stat.fmt_last  = (r_fcnt == C_LAST);
        o_stat.off_bad   = (r_off[1:0] != 2'b00) || (r_off < OFS_W'(4)) || (fhc >= C_NWORDS);
        o_stat.tag_alloc = r_rdata[0];
        o_stat.fits      = (rszc >= C_MIN) && ((rszc >> 2) <= (C_NWORDS - basec));
        o_stat.fit_ok    = !r_rdata[0] && (rszc >= needc);
        o_stat.rest_nz   = (restc != '0);
        o_stat.walk_end  = ((hc + (rszc >> 2)) >= C_NWORDS);
        o_stat.nx_in     = (nxc < C_NWORDS);
        o_stat.h_nz      = (r_h != '0);
        o_stat.prev_ok   = (rszc >= C_MIN) && ((rszc >> 2) <= hc);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RA_H:    raddr_c = hc;
            RA_NX:   raddr_c = nxc;
            RA_PREV: raddr_c = hc - C_ONE;
            default: raddr_c = hc;
        endcase
    end

    always_comb begin
        waddr_c = hc;
        wdata_c = '0;
        case (i_cmd.wr_sel)
            WS_FMT: begin
                waddr_c = CW'(r_fcnt);
                wdata_c = (r_fcnt == '0 || r_fcnt == C_LAST) ? C_HEAP : '0;
            end
            WS_A_HDR: begin
                waddr_c = hc;
                wdata_c = needc | C_ONE;
            end
            WS_A_FTR: begin
                waddr_c = hc + (needc >> 2) - C_ONE;
                wdata_c = needc | C_ONE;
            end
            WS_A_RHDR: begin
                waddr_c = hc + (needc >> 2);
                wdata_c = restc;
            end
            WS_A_RFTR: begin
                waddr_c = nxc - C_ONE;
                wdata_c = restc;
            end
            WS_SZ_HDR: begin
                waddr_c = hc;
                wdata_c = szc;
            end
            WS_SZ_FTR: begin
                waddr_c = nxc - C_ONE;
                wdata_c = szc;
            end
            WS_P_HDR: begin
                waddr_c = hc - (rszc >> 2);
                wdata_c = rszc + szc;
            end
            WS_P_FTR: begin
                waddr_c = nxc - C_ONE;
                wdata_c = rszc + szc;
            end
            default: begin
                waddr_c = hc;
                wdata_c = '0;
            end
        endcase
    end

    assign waddr = waddr_c[AW-1:0];
    assign wdata = wdata_c[TW-1:0];

    // heap store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[raddr_c[AW-1:0]];
            r_base  <= raddr_c[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (i_cmd.wr_en && i_cmd.wr_sel == WS_FMT && r_fcnt == C_LAST) begin
            r_fmt <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_req    <= i_req;
            r_off    <= i_off;
            r_fcnt   <= '0;
        end else if (i_cmd.wr_en && i_cmd.wr_sel == WS_FMT) begin
            r_fcnt <= r_fcnt + AW'(1);
        end

        case (i_cmd.h_op)
            H_ZERO:  r_h <= '0;
            H_OFF:   r_h <= fhc[HW-1:0];
            H_ADV:   r_h <= r_h + HW'(rszc >> 2);
            default: r_h <= r_h;
        endcase

        case (i_cmd.sz_op)
            SZ_LOAD: r_sz <= rszc[TW-1:0];
            SZ_ADD:  r_sz <= TW'(szc + rszc);
            default: r_sz <= r_sz;
        endcase

        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_ofs    <= i_cmd.res_ofs ? ofs_full[OFS_W-1:0] : '0;
        end

        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_ofs    <= r_res_ofs;
        end
    end

    assign o_status = r_o_status;
    assign o_ofs    = r_o_ofs;

endmodule

>>> rtl/bta_ctrl.sv
// Sequencer of the allocator: format sweep, first-fit walk, split and merge steps, handshakes.
module bta_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  bta_pkg::t_stat i_stat,
    output bta_pkg::t_cmd  o_cmd
);
    import bta_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE = 23'(1) << 0,
        S_DEC  = 23'(1) << 1,
        S_FMT  = 23'(1) << 2,
        S_ACHK = 23'(1) << 3,
        S_WRD  = 23'(1) << 4,
        S_WEV  = 23'(1) << 5,
        S_AW0  = 23'(1) << 6,
        S_AW1  = 23'(1) << 7,
        S_AW2  = 23'(1) << 8,
        S_AW3  = 23'(1) << 9,
        S_FRD  = 23'(1) << 10,
        S_FEV  = 23'(1) << 11,
        S_FW0  = 23'(1) << 12,
        S_FW1  = 23'(1) << 13,
        S_NRD  = 23'(1) << 14,
        S_NEV  = 23'(1) << 15,
        S_NW0  = 23'(1) << 16,
        S_NW1  = 23'(1) << 17,
        S_PRD  = 23'(1) << 18,
        S_PEV  = 23'(1) << 19,
        S_PW0  = 23'(1) << 20,
        S_PW1  = 23'(1) << 21,
        S_DONE = 23'(1) << 22
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_alloc) begin
                    if (i_stat.req_zero) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_ZERO;
                        n_state        = S_DONE;
                    end else if (!i_stat.formatted) begin
                        n_state = S_FMT;
                    end else begin
                        n_state = S_ACHK;
                    end
                end else begin
                    // free always answers ok with a zero offset
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_OK;
                    if (!i_stat.formatted || i_stat.off_bad) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.h_op = H_OFF;
                        n_state    = S_FRD;
                    end
                end
            end
            S_FMT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_FMT;
                if (i_stat.fmt_last) begin
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (i_stat.need_big) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_NOMEM;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.h_op = H_ZERO;
                    n_state    = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_H;
                n_state      = S_WEV;
            end
            S_WEV: begin
                if (!i_stat.fits) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_NOMEM;
                    n_state        = S_DONE;
                end else if (i_stat.fit_ok) begin
                    o_cmd.sz_op = SZ_LOAD;
                    n_state     = S_AW0;
                end else begin
                    o_cmd.h_op = H_ADV;
                    if (i_stat.walk_end) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_NOMEM;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            S_AW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_A_HDR;
                n_state      = S_AW1;
            end
            S_AW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_A_FTR;
                if (i_stat.rest_nz) begin
                    n_state = S_AW2;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_OK;
                    o_cmd.res_ofs  = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_AW2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_A_RHDR;
                n_state      = S_AW3;
            end
            S_AW3: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WS_A_RFTR;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = ST_OK;
                o_cmd.res_ofs  = 1'b1;
                n_state        = S_DONE;
            end
            S_FRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_H;
                n_state      = S_FEV;
            end
            S_FEV: begin
                if (!i_stat.tag_alloc || !i_stat.fits) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sz_op = SZ_LOAD;
                    n_state     = S_FW0;
                end
            end
            S_FW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_SZ_HDR;
                n_state      = S_FW1;
            end
            S_FW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_SZ_FTR;
                if (i_stat.nx_in) begin
                    n_state = S_NRD;
                end else if (i_stat.h_nz) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_NX;
                n_state      = S_NEV;
            end
            S_NEV: begin
                if (!i_stat.tag_alloc && i_stat.fits) begin
                    o_cmd.sz_op = SZ_ADD;
                    n_state     = S_NW0;
                end else if (i_stat.h_nz) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_SZ_HDR;
                n_state      = S_NW1;
            end
            S_NW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_SZ_FTR;
                n_state      = i_stat.h_nz ? S_PRD : S_DONE;
            end
            S_PRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_PREV;
                n_state      = S_PEV;
            end
            S_PEV: begin
                n_state = (!i_stat.tag_alloc && i_stat.prev_ok) ? S_PW0 : S_DONE;
            end
            S_PW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_P_HDR;
                n_state      = S_PW1;
            end
            S_PW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_P_FTR;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_m_tvalid = r_ovalid;

endmodule

>>> sim/tb.sv
// Self-checking testbench of the boundary-tag first-fit heap allocator.
`timescale 1ns / 100ps

module tb;
    import bta_pkg::*;

    localparam int HEAP_BYTES  = DEF_HEAP_BYTES;
    localparam int HEAP_WORDS  = HEAP_BYTES / 4;
    localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 24;    // longer than the longest free
    localparam int HOLD_CYCLES = 400;   // one long receiver hold-off
    localparam int HOLD_AT     = 150;   // input beats accepted before the hold-off
    localparam int RAND_ITEMS  = 600;
    localparam int QUIET_FROM  = 400;   // random item from which nobody idles

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // One answer of the block, as it leaves on the master side.
    typedef struct packed {
        t_status           status;
        logic [OFS_W-1:0]  payload;
    } t_alloc_answer;

    // One row of the directed plan; chk marks a hand-typed answer.
    typedef struct packed {
        logic              act;
        logic [REQ_W-1:0]  size;
        logic [OFS_W-1:0]  offset;
        logic              chk;
        t_status           status;
        logic [OFS_W-1:0]  payload;
    } t_plan_row;

    localparam int PLAN_ROWS = 25;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // request_size [10:0], block_offset [20:11], zero fill
    logic                   i_s_tuser;   // action: 0 allocate, 1 free
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // status [1:0], payload_offset [11:2], zero fill

    // Image of the heap as the allocator should hold it.
    logic [10:0]   heap_img [HEAP_WORDS];
    bit            heap_ready;

    t_alloc_answer pending_answers [$];
    int            n_errors;
    int            n_answers;
    int            beats_in;
    int            idle_cycles;
    bit            tx_gaps;
    bit            rx_gaps;

    // Hand-typed rows cover reset, extremes and error codes; the rest rely on the
    // image. The heap returns to one free block by the last row.
    t_plan_row dir_plan [PLAN_ROWS] = '{
        '{OP_FREE,  11'd0,    10'd4,    1'b1, ST_OK,    10'd0},  // free before formatting
        '{OP_ALLOC, 11'd0,    10'd0,    1'b1, ST_ZERO,  10'd0},  // zero size, no formatting
        '{OP_ALLOC, 11'd1016, 10'd0,    1'b1, ST_OK,    10'd4},  // formats, takes whole heap
        '{OP_ALLOC, 11'd1,    10'd0,    1'b1, ST_NOMEM, 10'd0},  // heap full
        '{OP_ALLOC, 11'd1024, 10'd0,    1'b1, ST_NOMEM, 10'd0},  // oversized
        '{OP_FREE,  11'd0,    10'd4,    1'b1, ST_OK,    10'd0},
        '{OP_FREE,  11'd2047, 10'd4,    1'b1, ST_OK,    10'd0},  // already free
        '{OP_ALLOC, 11'd1,    10'd0,    1'b0, ST_OK,    10'd0},
        '{OP_ALLOC, 11'd8,    10'd1023, 1'b0, ST_OK,    10'd0},
        '{OP_ALLOC, 11'd1023, 10'd0,    1'b1, ST_NOMEM, 10'd0},  // rounds past the heap
        '{OP_ALLOC, 11'd100,  10'd0,    1'b0, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd20,   1'b0, ST_OK,    10'd0},  // both neighbours taken
        '{OP_FREE,  11'd0,    10'd20,   1'b0, ST_OK,    10'd0},  // already free
        '{OP_FREE,  11'd0,    10'd6,    1'b1, ST_OK,    10'd0},  // unaligned
        '{OP_FREE,  11'd0,    10'd0,    1'b1, ST_OK,    10'd0},  // below first payload
        '{OP_FREE,  11'd0,    10'd1023, 1'b1, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd1020, 1'b0, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd4,    1'b0, ST_OK,    10'd0},  // merge with next
        '{OP_ALLOC, 11'd24,   10'd0,    1'b0, ST_OK,    10'd0},  // exact fit, no split
        '{OP_FREE,  11'd0,    10'd36,   1'b0, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd4,    1'b0, ST_OK,    10'd0},
        '{OP_ALLOC, 11'd500,  10'd0,    1'b0, ST_OK,    10'd0},
        '{OP_ALLOC, 11'd500,  10'd0,    1'b0, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd4,    1'b0, ST_OK,    10'd0},
        '{OP_FREE,  11'd0,    10'd516,  1'b0, ST_OK,    10'd0}   // merge with previous
    };

    boundary_tag_first_fit_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- heap image

    function automatic int unsigned tag_bytes(input logic [10:0] tag);
        return {tag[10:1], 1'b0};
    endfunction

    // True when a block of sz bytes with its header at word w lies inside the heap.
    function automatic bit block_in_heap(input int unsigned w, input int unsigned sz);
        return sz >= MIN_BLOCK && w < HEAP_WORDS && sz / 4 <= HEAP_WORDS - w;
    endfunction

    function automatic void first_fit_alloc(input int unsigned req, output t_status st,
                                            output logic [OFS_W-1:0] payload);
        int unsigned need;
        int unsigned h;
        int unsigned sz;
        logic [10:0] tag;
        payload = '0;
        st      = ST_NOMEM;
        if (req == 0) begin
            st = ST_ZERO;
            return;
        end
        need = ((req + 7) & 32'hFFFF_FFF8) + 8;
        // The first non-zero request formats, even when it cannot be met.
        if (!heap_ready) begin
            foreach (heap_img[i]) heap_img[i] = '0;
            heap_img[0]            = 11'(HEAP_BYTES);
            heap_img[HEAP_WORDS-1] = 11'(HEAP_BYTES);
            heap_ready             = 1'b1;
        end
        if (need > HEAP_BYTES) return;
        h = 0;
        while (h < HEAP_WORDS) begin
            tag = heap_img[h];
            sz  = tag_bytes(tag);
            // A corrupt tag ends the walk with no memory.
            if (!block_in_heap(h, sz)) return;
            if (!tag[0] && sz >= need) begin
                heap_img[h]                = 11'(need | 1);
                heap_img[h + need / 4 - 1] = 11'(need | 1);
                if (sz != need) begin
                    heap_img[h + need / 4]   = 11'(sz - need);
                    heap_img[h + sz / 4 - 1] = 11'(sz - need);
                end
                payload = OFS_W'((h + 1) * 4);
                st      = ST_OK;
                return;
            end
            h += sz / 4;
        end
    endfunction

    function automatic void release_block(input int unsigned off);
        int unsigned h;
        int unsigned sz;
        int unsigned nx;
        int unsigned nsz;
        int unsigned psz;
        if (!heap_ready || off % 4 != 0 || off < 4) return;
        h = off / 4 - 1;
        if (h >= HEAP_WORDS || !heap_img[h][0]) return;
        sz = tag_bytes(heap_img[h]);
        if (!block_in_heap(h, sz)) return;
        heap_img[h]              = 11'(sz);
        heap_img[h + sz / 4 - 1] = 11'(sz);
        // Absorb a free next neighbour with sane tags.
        nx = h + sz / 4;
        if (nx < HEAP_WORDS && !heap_img[nx][0]) begin
            nsz = tag_bytes(heap_img[nx]);
            if (block_in_heap(nx, nsz)) begin
                sz += nsz;
                heap_img[h]              = 11'(sz);
                heap_img[h + sz / 4 - 1] = 11'(sz);
            end
        end
        // Then fold into a free previous neighbour, found through its footer.
        if (h > 0 && !heap_img[h-1][0]) begin
            psz = tag_bytes(heap_img[h-1]);
            if (psz >= MIN_BLOCK && psz / 4 <= h) begin
                heap_img[h - psz / 4]    = 11'(psz + sz);
                heap_img[h + sz / 4 - 1] = 11'(psz + sz);
            end
        end
    endfunction

    // ---------------------------------------------------------------- slave side

    // Offer one beat, hold it until accepted, then update the image and queue
    // the answer. Return at the following falling edge with tvalid still high.
    task automatic send_beat(input logic act, input logic [REQ_W-1:0] size,
                             input logic [OFS_W-1:0] offset, input logic chk,
                             input t_alloc_answer typed_ans, output t_alloc_answer got);
        t_alloc_answer ans;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = act;
        i_s_tdata  = {3'b000, offset, size};
        do @(posedge i_clk); while (!o_s_tready);
        ans.status  = ST_OK;
        ans.payload = '0;
        if (act == OP_ALLOC)
            first_fit_alloc(size, ans.status, ans.payload);
        else
            release_block(offset);
        pending_answers.push_back(chk ? typed_ans : ans);
        got = ans;
        beats_in++;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] answer %0d: %s got %0d, want %0d", $realtime, n_answers, what, got,
                 want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_alloc_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected beat, status", o_m_tdata[1:0], -1);
            end else begin
                want = pending_answers.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", o_m_tdata[1:0], want.status);
                if (o_m_tdata[11:2] !== want.payload)
                    report_mismatch("payload_offset", o_m_tdata[11:2], want.payload);
            end
            n_answers++;
        end
    end

    // Give up when neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- master side

    // Drop tready in random bursts; once, hold it low long enough to fill the
    // block and back-pressure the slave side.
    initial begin
        bit held;
        held       = 1'b0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && beats_in >= HOLD_AT) begin
                held       = 1'b1;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_m_tready = 1'b1;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        logic [OFS_W-1:0] live [$];
        logic [OFS_W-1:0] last_freed;
        logic [OFS_W-1:0] off;
        t_alloc_answer    typed_ans;
        t_alloc_answer    got;
        int               roll;
        int               noise;
        int               idx;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_ALLOC;
        heap_ready  = 1'b0;
        n_errors    = 0;
        n_answers   = 0;
        beats_in    = 0;
        idle_cycles = 0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        last_freed  = 10'd4;
        typed_ans   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed plan: reset behaviour, extremes, every special case.
        foreach (dir_plan[i]) begin
            typed_ans.status  = dir_plan[i].status;
            typed_ans.payload = dir_plan[i].payload;
            send_beat(dir_plan[i].act, dir_plan[i].size, dir_plan[i].offset,
                      dir_plan[i].chk, typed_ans, got);
        end

        // Random part: mostly allocate and free of live blocks, with a little
        // noise (zero and near-heap-size requests, stray and repeated frees).
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == QUIET_FROM) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            noise = (n < QUIET_FROM) ? 6 : 12;
            roll  = $urandom_range(0, 99);
            if (roll < noise) begin
                case ($urandom_range(0, 3))
                    0: send_beat(OP_ALLOC, '0, OFS_W'($urandom), 1'b0, typed_ans, got);
                    1: send_beat(OP_ALLOC, REQ_W'($urandom_range(1009, 1024)),
                                 OFS_W'($urandom), 1'b0, typed_ans, got);
                    2: send_beat(OP_FREE, REQ_W'($urandom), OFS_W'($urandom), 1'b0,
                                 typed_ans, got);
                    default: send_beat(OP_FREE, REQ_W'($urandom), last_freed, 1'b0,
                                       typed_ans, got);
                endcase
            end else if (live.size() == 0 || roll < noise + 50) begin
                send_beat(OP_ALLOC,
                          ($urandom_range(0, 7) == 0) ? REQ_W'($urandom_range(65, 400))
                                                      : REQ_W'($urandom_range(1, 64)),
                          OFS_W'($urandom), 1'b0, typed_ans, got);
                if (got.status == ST_OK) live.push_back(got.payload);
            end else begin
                idx = $urandom_range(0, live.size() - 1);
                off = live[idx];
                live.delete(idx);
                send_beat(OP_FREE, REQ_W'($urandom), off, 1'b0, typed_ans, got);
                last_freed = off;
            end
        end
        i_s_tvalid = 1'b0;

        // Drain, then let any stray beat show up before the verdict.
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> boundary_tag_first_fit_allocator.f
rtl/bta_pkg.sv
rtl/bta_dp.sv
rtl/bta_ctrl.sv
rtl/boundary_tag_first_fit_allocator.sv
sim/tb.sv
